// ===== hdl/evg_pkg.sv =====
// Shared constants, an arctangent lookup function and pipeline tag types for the ellipse vertex generator.
`default_nettype none

package evg_pkg;

   // Parameter defaults.
   localparam int MAX_POINTS_DEF    = 1024;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN          = 24;

   // Fixed field and datapath widths.
   localparam int COUNT_W = 11;
   localparam int DATA_W  = 32;
   localparam int PHASE_W = 32;
   localparam int ANG_W   = 33;
   localparam int CRD_W   = 34;
   localparam int OFS_W   = 34;
   localparam int MAG_W   = 32;
   localparam int SQ_W    = 64;
   localparam int QUO_W   = 16;
   localparam int NRM_W   = 16;
   localparam int ADDR_W  = 5;

   // Fixed-point constants in Q2.30.
   localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

   // Register indexes.
   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_FULL_WIDTH  = 3'd2;
   localparam logic [2:0] REG_FULL_HEIGHT = 3'd3;
   localparam logic [2:0] REG_DEPTH_Z     = 3'd4;
   localparam logic [2:0] REG_POINT_COUNT = 3'd5;
   localparam logic [2:0] REG_FILL_MODE   = 3'd6;

   // Arctangent of 2^-k in Q2.30.
   function automatic logic [31:0] atan_q30(input int k);
      logic [31:0] v;
      unique case (k)
         0:  v = 32'h3243F6A8;
         1:  v = 32'h1DAC6705;
         2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;
         4:  v = 32'h03FEAB76;
         5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;
         7:  v = 32'h007FFF55;
         8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   // Sideband through the phase divider.
   typedef struct packed {
      logic center;
      logic err;
   } div_tag_type;

   // Sideband through the rotator.
   typedef struct packed {
      logic       center;
      logic       err;
      logic [1:0] quad;
   } rot_tag_type;

   // Sideband once the offsets are known.
   typedef struct packed {
      logic              center;
      logic              err;
      logic              zero;
      logic              sx;
      logic              sy;
      logic [DATA_W-1:0] px;
      logic [DATA_W-1:0] py;
   } vec_tag_type;

   // Sideband through the square root chain.
   typedef struct packed {
      vec_tag_type      vec;
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
   } root_tag_type;

endpackage

`default_nettype wire

// ===== hdl/evg_div_cell.sv =====
// One restoring division cell: develops one quotient bit and passes the word on.
`default_nettype none

module evg_div_cell #(
   parameter int RW = 32,
   parameter int QW = 16,
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          valid_i,
   input  wire logic [RW-1:0] rem_i,
   input  wire logic [RW-1:0] den_i,
   input  wire logic [QW-1:0] low_i,
   input  wire logic [TW-1:0] tag_i,
   output logic               valid_o,
   output logic      [RW-1:0] rem_o,
   output logic      [RW-1:0] den_o,
   output logic      [QW-1:0] low_o,
   output logic      [TW-1:0] tag_o
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] den_ff;
   logic [QW-1:0] low_ff, low_in;
   logic [TW-1:0] tag_ff;
   logic [RW:0]   trial;
   logic          ge;

   // Shift the next dividend bit in and try a subtraction.
   always_comb begin
      trial  = {rem_i, low_i[QW-1]};
      ge     = trial >= {1'b0, den_i};
      rem_in = ge ? RW'(trial - {1'b0, den_i}) : trial[RW-1:0];
      low_in = {low_i[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         low_ff <= low_in;
         tag_ff <= tag_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign den_o   = den_ff;
   assign low_o   = low_ff;
   assign tag_o   = tag_ff;

endmodule

`default_nettype wire

// ===== hdl/evg_cordic_cell.sv =====
// One rotation-mode CORDIC cell with a fixed shift.
`default_nettype none

module evg_cordic_cell #(
   parameter int K  = 0,
   parameter int TW = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        valid_i,
   input  wire logic signed [evg_pkg::CRD_W-1:0] x_i,
   input  wire logic signed [evg_pkg::CRD_W-1:0] y_i,
   input  wire logic signed [evg_pkg::ANG_W-1:0] z_i,
   input  wire logic [TW-1:0]                tag_i,
   output logic                             valid_o,
   output logic signed [evg_pkg::CRD_W-1:0] x_o,
   output logic signed [evg_pkg::CRD_W-1:0] y_o,
   output logic signed [evg_pkg::ANG_W-1:0] z_o,
   output logic [TW-1:0]                    tag_o
);

   localparam logic signed [evg_pkg::ANG_W-1:0] ATAN =
      evg_pkg::ANG_W'(evg_pkg::atan_q30(K));

   logic                             valid_ff;
   logic signed [evg_pkg::CRD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [evg_pkg::ANG_W-1:0] z_ff, z_in;
   logic [TW-1:0]                    tag_ff;

   // Rotate toward zero residual angle.
   always_comb begin
      if (!z_i[evg_pkg::ANG_W-1]) begin
         x_in = x_i - (y_i >>> K);
         y_in = y_i + (x_i >>> K);
         z_in = z_i - ATAN;
      end else begin
         x_in = x_i + (y_i >>> K);
         y_in = y_i - (x_i >>> K);
         z_in = z_i + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= tag_i;
      end
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign tag_o   = tag_ff;

endmodule

`default_nettype wire

// ===== hdl/evg_sqrt_cell.sv =====
// One digit-by-digit integer square root cell, settling one result bit.
`default_nettype none

module evg_sqrt_cell #(
   parameter int K  = 0,
   parameter int TW = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       valid_i,
   input  wire logic [evg_pkg::SQ_W-1:0]   s_i,
   input  wire logic [evg_pkg::SQ_W-1:0]   r_i,
   input  wire logic [TW-1:0]              tag_i,
   output logic                            valid_o,
   output logic [evg_pkg::SQ_W-1:0]        s_o,
   output logic [evg_pkg::SQ_W-1:0]        r_o,
   output logic [TW-1:0]                   tag_o
);

   localparam logic [evg_pkg::SQ_W-1:0] BIT =
      evg_pkg::SQ_W'(1) << (evg_pkg::SQ_W - 2 - 2 * K);

   logic                      valid_ff;
   logic [evg_pkg::SQ_W-1:0]  s_ff, s_in, r_ff, r_in;
   logic [TW-1:0]             tag_ff;
   logic [evg_pkg::SQ_W:0]    trial;
   logic                      ge;

   // Subtract the trial square when it fits.
   always_comb begin
      trial = {1'b0, r_i} + {1'b0, BIT};
      ge    = {1'b0, s_i} >= trial;
      s_in  = ge ? s_i - trial[evg_pkg::SQ_W-1:0] : s_i;
      r_in  = ge ? (r_i >> 1) + BIT : r_i >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= s_in;
         r_ff   <= r_in;
         tag_ff <= tag_i;
      end
   end

   assign valid_o = valid_ff;
   assign s_o     = s_ff;
   assign r_o     = r_ff;
   assign tag_o   = tag_ff;

endmodule

`default_nettype wire

// ===== hdl/ellipse_vertex_generator.sv =====
// Top level of the ellipse vertex generator: registers, cell chains and glue stages.
//
// The req channel carries one vertex index per word; the rsp channel returns one vertex
// word per index, in order: position, unit normal and the center and error flags.
// The user must write configuration over the csr port (register i at byte 4*i) only
// while no word is in flight; the block does not enforce it. Reads return stored values.
//
// The pipeline is built from chains of cells: 32 phase divider cells, the CORDIC
// cells, 32 square root cells and two parallel chains of 16 normal divider cells,
// plus eleven glue stages. Unless stalled, one word enters and one leaves every cycle.
//
// The whole pipeline moves as one. When the output register holds a word and
// rsp_stall is high, every stage holds and req_stall is raised; otherwise a new
// index is taken each cycle, also while the last word is being taken.
//
// Reset clears all valid bits and returns the registers to their reset values
// (point count 2, everything else zero).
`default_nettype none

module ellipse_vertex_generator #(
   parameter int MAX_POINTS    = evg_pkg::MAX_POINTS_DEF,
   parameter int CORDIC_STAGES = evg_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [evg_pkg::COUNT_W-1:0]      req_vertex_index,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [evg_pkg::DATA_W-1:0]     rsp_pos_x,
   output logic signed [evg_pkg::DATA_W-1:0]     rsp_pos_y,
   output logic signed [evg_pkg::DATA_W-1:0]     rsp_pos_z,
   output logic signed [evg_pkg::NRM_W-1:0]      rsp_normal_x,
   output logic signed [evg_pkg::NRM_W-1:0]      rsp_normal_y,
   output logic                                  rsp_is_center,
   output logic                                  rsp_index_error,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [evg_pkg::ADDR_W-1:0]       csr_paddr,
   input  wire logic [evg_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [evg_pkg::DATA_W-1:0]            csr_prdata,
   output logic                                  csr_pready
);

   localparam int CW  = evg_pkg::COUNT_W;
   localparam int DW  = evg_pkg::DATA_W;
   localparam int PW  = evg_pkg::PHASE_W;
   localparam int AW  = evg_pkg::ANG_W;
   localparam int RW  = evg_pkg::CRD_W;
   localparam int OW  = evg_pkg::OFS_W;
   localparam int MW  = evg_pkg::MAG_W;
   localparam int SW  = evg_pkg::SQ_W;
   localparam int QW  = evg_pkg::QUO_W;
   localparam int NW  = evg_pkg::NRM_W;
   localparam int DTW = $bits(evg_pkg::div_tag_type);
   localparam int RTW = $bits(evg_pkg::rot_tag_type);
   localparam int VTW = $bits(evg_pkg::vec_tag_type);
   localparam int STW = $bits(evg_pkg::root_tag_type);
   localparam int PRW = DW + RW;
   localparam int NUW = MW + QW;

   // ---------------------------------------------------------------- registers
   logic [DW-1:0] center_x_ff, center_y_ff, full_width_ff, full_height_ff, depth_z_ff;
   logic [CW-1:0] point_count_ff;
   logic          fill_mode_ff;
   logic [2:0]    csr_index;
   logic          csr_write;

   assign csr_index  = csr_paddr[evg_pkg::ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         full_width_ff  <= '0;
         full_height_ff <= '0;
         depth_z_ff     <= '0;
         point_count_ff <= CW'(2);
         fill_mode_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            evg_pkg::REG_CENTER_X:    center_x_ff    <= csr_pwdata;
            evg_pkg::REG_CENTER_Y:    center_y_ff    <= csr_pwdata;
            evg_pkg::REG_FULL_WIDTH:  full_width_ff  <= csr_pwdata;
            evg_pkg::REG_FULL_HEIGHT: full_height_ff <= csr_pwdata;
            evg_pkg::REG_DEPTH_Z:     depth_z_ff     <= csr_pwdata;
            evg_pkg::REG_POINT_COUNT: point_count_ff <= csr_pwdata[CW-1:0];
            evg_pkg::REG_FILL_MODE:   fill_mode_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_index)
         evg_pkg::REG_CENTER_X:    csr_prdata = center_x_ff;
         evg_pkg::REG_CENTER_Y:    csr_prdata = center_y_ff;
         evg_pkg::REG_FULL_WIDTH:  csr_prdata = full_width_ff;
         evg_pkg::REG_FULL_HEIGHT: csr_prdata = full_height_ff;
         evg_pkg::REG_DEPTH_Z:     csr_prdata = depth_z_ff;
         evg_pkg::REG_POINT_COUNT: csr_prdata = DW'(point_count_ff);
         evg_pkg::REG_FILL_MODE:   csr_prdata = DW'(fill_mode_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   logic en;
   logic rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------------------------------------------------------- index decode
   logic [CW-1:0] n_eff, idx_i, den_in, rem0_in;
   logic [CW:0]   limit;
   evg_pkg::div_tag_type s0_tag_in;
   logic          s0_valid_ff;
   logic [CW-1:0] s0_rem_ff, s0_den_ff;
   logic [DTW-1:0] s0_tag_ff;

   // Clamp the point count, flag the special indexes and do the first divide step.
   always_comb begin
      if (point_count_ff < CW'(2)) begin
         n_eff = CW'(2);
      end else if (32'(point_count_ff) > 32'(MAX_POINTS)) begin
         n_eff = CW'(MAX_POINTS);
      end else begin
         n_eff = point_count_ff;
      end
      limit            = {1'b0, n_eff} + (CW + 1)'(fill_mode_ff);
      s0_tag_in.err    = {1'b0, req_vertex_index} >= limit;
      s0_tag_in.center = fill_mode_ff && (req_vertex_index == '0);
      idx_i            = req_vertex_index - CW'(fill_mode_ff);
      den_in           = n_eff - CW'(1);
      rem0_in          = (idx_i >= den_in) ? idx_i - den_in : idx_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_rem_ff <= rem0_in;
         s0_den_ff <= den_in;
         s0_tag_ff <= s0_tag_in;
      end
   end

   // ---------------------------------------------------------------- phase divider
   logic           ph_valid [0:PW];
   logic [CW-1:0]  ph_rem   [0:PW];
   logic [CW-1:0]  ph_den   [0:PW];
   logic [PW-1:0]  ph_low   [0:PW];
   logic [DTW-1:0] ph_tag   [0:PW];

   assign ph_valid[0] = s0_valid_ff;
   assign ph_rem[0]   = s0_rem_ff;
   assign ph_den[0]   = s0_den_ff;
   assign ph_low[0]   = '0;
   assign ph_tag[0]   = s0_tag_ff;

   for (genvar g = 0; g < PW; g++) begin : g_phase
      evg_div_cell #(.RW(CW), .QW(PW), .TW(DTW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(ph_valid[g]), .rem_i(ph_rem[g]), .den_i(ph_den[g]),
         .low_i(ph_low[g]), .tag_i(ph_tag[g]),
         .valid_o(ph_valid[g+1]), .rem_o(ph_rem[g+1]), .den_o(ph_den[g+1]),
         .low_o(ph_low[g+1]), .tag_o(ph_tag[g+1])
      );
   end

   // ---------------------------------------------------------------- angle
   logic [60:0]              ang_prod;
   evg_pkg::div_tag_type     ph_tag_out;
   evg_pkg::rot_tag_type     ang_tag_in;
   logic                     ang_valid_ff;
   logic signed [AW-1:0]     ang_z_ff;
   logic [RTW-1:0]           ang_tag_ff;

   // Scale the fraction of a quadrant to radians.
   always_comb begin
      ph_tag_out        = ph_tag[PW];
      ang_prod          = 61'(ph_low[PW][PW-3:0]) * 61'(evg_pkg::HALF_PI_Q30);
      ang_tag_in.center = ph_tag_out.center;
      ang_tag_in.err    = ph_tag_out.err;
      ang_tag_in.quad   = ph_low[PW][PW-1:PW-2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_valid_ff <= 1'b0;
      end else if (en) begin
         ang_valid_ff <= ph_valid[PW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_z_ff   <= AW'(ang_prod[60:30]);
         ang_tag_ff <= ang_tag_in;
      end
   end

   // ---------------------------------------------------------------- CORDIC
   logic                 cr_valid [0:CORDIC_STAGES];
   logic signed [RW-1:0] cr_x     [0:CORDIC_STAGES];
   logic signed [RW-1:0] cr_y     [0:CORDIC_STAGES];
   logic signed [AW-1:0] cr_z     [0:CORDIC_STAGES];
   logic [RTW-1:0]       cr_tag   [0:CORDIC_STAGES];

   assign cr_valid[0] = ang_valid_ff;
   assign cr_x[0]     = RW'(evg_pkg::CORDIC_GAIN_Q30);
   assign cr_y[0]     = '0;
   assign cr_z[0]     = ang_z_ff;
   assign cr_tag[0]   = ang_tag_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      evg_cordic_cell #(.K(g), .TW(RTW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(cr_valid[g]), .x_i(cr_x[g]), .y_i(cr_y[g]), .z_i(cr_z[g]),
         .tag_i(cr_tag[g]),
         .valid_o(cr_valid[g+1]), .x_o(cr_x[g+1]), .y_o(cr_y[g+1]), .z_o(cr_z[g+1]),
         .tag_o(cr_tag[g+1])
      );
   end

   // ---------------------------------------------------------------- quadrant
   evg_pkg::rot_tag_type cr_tag_out;
   logic signed [RW-1:0] cos_in, sin_in, cos_ff, sin_ff;
   logic                 qd_valid_ff;
   logic [RTW-1:0]       qd_tag_ff;

   // Rotate the first-quadrant result into place.
   always_comb begin
      cr_tag_out = cr_tag[CORDIC_STAGES];
      unique case (cr_tag_out.quad)
         2'd0: begin
            cos_in = cr_x[CORDIC_STAGES];
            sin_in = cr_y[CORDIC_STAGES];
         end
         2'd1: begin
            cos_in = -cr_y[CORDIC_STAGES];
            sin_in = cr_x[CORDIC_STAGES];
         end
         2'd2: begin
            cos_in = -cr_x[CORDIC_STAGES];
            sin_in = -cr_y[CORDIC_STAGES];
         end
         default: begin
            cos_in = cr_y[CORDIC_STAGES];
            sin_in = -cr_x[CORDIC_STAGES];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qd_valid_ff <= 1'b0;
      end else if (en) begin
         qd_valid_ff <= cr_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         qd_tag_ff <= cr_tag_out;
      end
   end

   // ---------------------------------------------------------------- radius multiply
   logic signed [PRW-1:0] mx_in, my_in, mx_ff, my_ff;
   logic                  mu_valid_ff;
   logic [RTW-1:0]        mu_tag_ff;

   assign mx_in = $signed(full_width_ff) * cos_ff;
   assign my_in = $signed(full_height_ff) * sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else if (en) begin
         mu_valid_ff <= qd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff     <= mx_in;
         my_ff     <= my_in;
         mu_tag_ff <= qd_tag_ff;
      end
   end

   // ---------------------------------------------------------------- rounding
   localparam logic signed [PRW-1:0] ROUND_HALF = PRW'(1) <<< 30;
   logic signed [PRW-1:0] rx_sum, ry_sum;
   logic signed [OW-1:0]  tx_ff, ty_ff;
   logic                  rd_valid_ff;
   logic [RTW-1:0]        rd_tag_ff;

   // Halve the width and drop back to Q16.16, rounding half up.
   assign rx_sum = mx_ff + ROUND_HALF;
   assign ry_sum = my_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (en) begin
         rd_valid_ff <= mu_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff     <= rx_sum[OW+30:31];
         ty_ff     <= ry_sum[OW+30:31];
         rd_tag_ff <= mu_tag_ff;
      end
   end

   // ---------------------------------------------------------------- positions and magnitudes
   evg_pkg::rot_tag_type rd_tag_out;
   evg_pkg::vec_tag_type ab_tag_in;
   logic signed [OW-1:0] abs_x, abs_y;
   logic [MW-1:0]        ax_in, ay_in, ax_ff, ay_ff;
   logic                 ab_valid_ff;
   logic [VTW-1:0]       ab_tag_ff;

   always_comb begin
      rd_tag_out       = rd_tag_ff;
      abs_x            = tx_ff[OW-1] ? -tx_ff : tx_ff;
      abs_y            = ty_ff[OW-1] ? -ty_ff : ty_ff;
      ax_in            = abs_x[MW-1:0];
      ay_in            = abs_y[MW-1:0];
      ab_tag_in.center = rd_tag_out.center;
      ab_tag_in.err    = rd_tag_out.err;
      ab_tag_in.zero   = (ax_in == '0) && (ay_in == '0);
      ab_tag_in.sx     = tx_ff[OW-1];
      ab_tag_in.sy     = ty_ff[OW-1];
      ab_tag_in.px     = center_x_ff + tx_ff[DW-1:0];
      ab_tag_in.py     = center_y_ff + ty_ff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ab_valid_ff <= 1'b0;
      end else if (en) begin
         ab_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         ab_tag_ff <= ab_tag_in;
      end
   end

   // ---------------------------------------------------------------- normalize
   logic [MW-1:0]  nx_in, ny_in, nm, nx_ff, ny_ff;
   logic           nm_valid_ff;
   logic [VTW-1:0] nm_tag_ff;

   // Shift both magnitudes up together until the larger reaches 2^29.
   always_comb begin
      nx_in = ax_ff;
      ny_in = ay_ff;
      for (int s = 16; s >= 1; s = s / 2) begin
         nm = (nx_in > ny_in) ? nx_in : ny_in;
         if (nm < (MW'(1) << (30 - s))) begin
            nx_in = nx_in << s;
            ny_in = ny_in << s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_valid_ff <= 1'b0;
      end else if (en) begin
         nm_valid_ff <= ab_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff     <= nx_in;
         ny_ff     <= ny_in;
         nm_tag_ff <= ab_tag_ff;
      end
   end

   // ---------------------------------------------------------------- squares
   logic [SW-1:0]  sqx_ff, sqy_ff;
   logic [MW-1:0]  sq_ax_ff, sq_ay_ff;
   logic           sq_valid_ff;
   logic [VTW-1:0] sq_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= nm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff    <= SW'(nx_ff) * SW'(nx_ff);
         sqy_ff    <= SW'(ny_ff) * SW'(ny_ff);
         sq_ax_ff  <= nx_ff;
         sq_ay_ff  <= ny_ff;
         sq_tag_ff <= nm_tag_ff;
      end
   end

   // ---------------------------------------------------------------- sum of squares
   evg_pkg::root_tag_type su_tag_in;
   logic [SW-1:0]  su_sum_ff;
   logic           su_valid_ff;
   logic [STW-1:0] su_tag_ff;

   always_comb begin
      su_tag_in.vec = sq_tag_ff;
      su_tag_in.ax  = sq_ax_ff;
      su_tag_in.ay  = sq_ay_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su_valid_ff <= 1'b0;
      end else if (en) begin
         su_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         su_sum_ff <= sqx_ff + sqy_ff;
         su_tag_ff <= su_tag_in;
      end
   end

   // ---------------------------------------------------------------- square root
   logic           sr_valid [0:MW];
   logic [SW-1:0]  sr_s     [0:MW];
   logic [SW-1:0]  sr_r     [0:MW];
   logic [STW-1:0] sr_tag   [0:MW];

   assign sr_valid[0] = su_valid_ff;
   assign sr_s[0]     = su_sum_ff;
   assign sr_r[0]     = '0;
   assign sr_tag[0]   = su_tag_ff;

   for (genvar g = 0; g < MW; g++) begin : g_sqrt
      evg_sqrt_cell #(.K(g), .TW(STW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(sr_valid[g]), .s_i(sr_s[g]), .r_i(sr_r[g]), .tag_i(sr_tag[g]),
         .valid_o(sr_valid[g+1]), .s_o(sr_s[g+1]), .r_o(sr_r[g+1]), .tag_o(sr_tag[g+1])
      );
   end

   // ---------------------------------------------------------------- divide setup
   evg_pkg::root_tag_type sr_tag_out;
   logic [MW-1:0]  len;
   logic [NUW-1:0] numx, numy;
   logic           dp_valid_ff;
   logic [MW-1:0]  dp_len_ff, dp_remx_ff, dp_remy_ff;
   logic [QW-1:0]  dp_lowx_ff, dp_lowy_ff;
   logic [VTW-1:0] dp_tag_ff;
   logic           dp_sy_ff;

   // Numerator a*32768 + len/2; its top part is already below len.
   always_comb begin
      sr_tag_out = sr_tag[MW];
      len        = sr_r[MW][MW-1:0];
      numx       = NUW'({sr_tag_out.ax, 15'b0}) + NUW'(len >> 1);
      numy       = NUW'({sr_tag_out.ay, 15'b0}) + NUW'(len >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_valid_ff <= 1'b0;
      end else if (en) begin
         dp_valid_ff <= sr_valid[MW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_len_ff  <= len;
         dp_remx_ff <= numx[NUW-1:QW];
         dp_remy_ff <= numy[NUW-1:QW];
         dp_lowx_ff <= numx[QW-1:0];
         dp_lowy_ff <= numy[QW-1:0];
         dp_tag_ff  <= sr_tag_out.vec;
         dp_sy_ff   <= sr_tag_out.vec.sy;
      end
   end

   // ---------------------------------------------------------------- normal dividers
   logic           dx_valid [0:QW];
   logic [MW-1:0]  dx_rem   [0:QW];
   logic [MW-1:0]  dx_den   [0:QW];
   logic [QW-1:0]  dx_low   [0:QW];
   logic [VTW-1:0] dx_tag   [0:QW];
   logic           dy_valid [0:QW];
   logic [MW-1:0]  dy_rem   [0:QW];
   logic [MW-1:0]  dy_den   [0:QW];
   logic [QW-1:0]  dy_low   [0:QW];
   logic [0:0]     dy_tag   [0:QW];

   assign dx_valid[0] = dp_valid_ff;
   assign dx_rem[0]   = dp_remx_ff;
   assign dx_den[0]   = dp_len_ff;
   assign dx_low[0]   = dp_lowx_ff;
   assign dx_tag[0]   = dp_tag_ff;
   assign dy_valid[0] = dp_valid_ff;
   assign dy_rem[0]   = dp_remy_ff;
   assign dy_den[0]   = dp_len_ff;
   assign dy_low[0]   = dp_lowy_ff;
   assign dy_tag[0]   = dp_sy_ff;

   for (genvar g = 0; g < QW; g++) begin : g_norm
      evg_div_cell #(.RW(MW), .QW(QW), .TW(VTW)) u_cell_x (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(dx_valid[g]), .rem_i(dx_rem[g]), .den_i(dx_den[g]),
         .low_i(dx_low[g]), .tag_i(dx_tag[g]),
         .valid_o(dx_valid[g+1]), .rem_o(dx_rem[g+1]), .den_o(dx_den[g+1]),
         .low_o(dx_low[g+1]), .tag_o(dx_tag[g+1])
      );
      evg_div_cell #(.RW(MW), .QW(QW), .TW(1)) u_cell_y (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(dy_valid[g]), .rem_i(dy_rem[g]), .den_i(dy_den[g]),
         .low_i(dy_low[g]), .tag_i(dy_tag[g]),
         .valid_o(dy_valid[g+1]), .rem_o(dy_rem[g+1]), .den_o(dy_den[g+1]),
         .low_o(dy_low[g+1]), .tag_o(dy_tag[g+1])
      );
   end

   // ---------------------------------------------------------------- output register
   localparam logic [QW-1:0] NEG_LIMIT = QW'(32768);
   localparam logic [QW-1:0] POS_LIMIT = QW'(32767);

   evg_pkg::vec_tag_type dx_tag_out;
   logic [NW-1:0] norm_x, norm_y;
   logic [DW-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic [NW-1:0] nrm_x_in, nrm_y_in;
   logic [DW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [NW-1:0] nrm_x_ff, nrm_y_ff;
   logic          center_ff, err_ff;

   // Apply the sign with saturation, then pick the field values by vertex kind.
   always_comb begin
      dx_tag_out = dx_tag[QW];
      if (dx_tag_out.sx) begin
         norm_x = (dx_low[QW] > NEG_LIMIT) ? NEG_LIMIT : -dx_low[QW];
      end else begin
         norm_x = (dx_low[QW] > POS_LIMIT) ? POS_LIMIT : dx_low[QW];
      end
      if (dy_tag[QW][0]) begin
         norm_y = (dy_low[QW] > NEG_LIMIT) ? NEG_LIMIT : -dy_low[QW];
      end else begin
         norm_y = (dy_low[QW] > POS_LIMIT) ? POS_LIMIT : dy_low[QW];
      end
      priority if (dx_tag_out.err) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
         nrm_x_in = '0;
         nrm_y_in = '0;
      end else if (dx_tag_out.center) begin
         pos_x_in = center_x_ff;
         pos_y_in = center_y_ff;
         pos_z_in = depth_z_ff;
         nrm_x_in = '0;
         nrm_y_in = '0;
      end else begin
         pos_x_in = dx_tag_out.px;
         pos_y_in = dx_tag_out.py;
         pos_z_in = depth_z_ff;
         nrm_x_in = dx_tag_out.zero ? '0 : norm_x;
         nrm_y_in = dx_tag_out.zero ? '0 : norm_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dx_valid[QW] & dy_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         pos_z_ff  <= pos_z_in;
         nrm_x_ff  <= nrm_x_in;
         nrm_y_ff  <= nrm_y_in;
         center_ff <= dx_tag_out.center & ~dx_tag_out.err;
         err_ff    <= dx_tag_out.err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_normal_x    = nrm_x_ff;
   assign rsp_normal_y    = nrm_y_ff;
   assign rsp_is_center   = center_ff;
   assign rsp_index_error = err_ff;

endmodule

`default_nettype wire

// ===== hdl/evg_checker.sv =====
// Port-level assertions for the ellipse vertex generator and the bind that attaches them.
`default_nettype none

module evg_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [evg_pkg::DATA_W-1:0]   rsp_pos_x,
   input wire logic [evg_pkg::DATA_W-1:0]   rsp_pos_y,
   input wire logic [evg_pkg::DATA_W-1:0]   rsp_pos_z,
   input wire logic [evg_pkg::NRM_W-1:0]    rsp_normal_x,
   input wire logic [evg_pkg::NRM_W-1:0]    rsp_normal_y,
   input wire logic                         rsp_is_center,
   input wire logic                         rsp_index_error
);

   // A stalled result word stays valid and keeps its x and y positions and its normals.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_normal_x) && $stable(rsp_normal_y))
      else $error("stalled result word changed");

   // The input side only stalls behind a stuck result word.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stuck result");

   // An error word carries nothing else.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_pos_x == '0 && rsp_pos_y == '0
         && rsp_pos_z == '0 && rsp_normal_x == '0 && rsp_normal_y == '0 && !rsp_is_center)
      else $error("error word with nonzero fields");

   // The center vertex has no normal.
   a_center_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_center |-> rsp_normal_x == '0 && rsp_normal_y == '0)
      else $error("center vertex with a normal");

   // Nothing is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ellipse_vertex_generator evg_checker u_evg_checker (.*);

`default_nettype wire
